// ===== sv/normalized_edge_entropy_macros.svh =====
// Assertion macros for the normalized edge entropy block.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef NORMALIZED_EDGE_ENTROPY_MACROS_SVH
`define NORMALIZED_EDGE_ENTROPY_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define NEE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define NEE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/nee_pkg.sv =====
// Package for the normalized edge entropy block.
// Holds fixed widths, command and status types, and the controller states.
package nee_pkg;

   localparam int TOT_W    = 42;
   localparam int ACC_W    = 40;
   localparam int LOG_FRAC = 24;
   localparam int LG_INT_W = 6;
   localparam int LG_W     = LG_INT_W + LOG_FRAC;
   localparam int PROD_W   = 32 + LG_W;
   localparam int DIV_W    = 64;

   typedef enum logic [1:0] {
      LOG_TOTAL,
      LOG_TALLY,
      LOG_WEIGHT
   } log_sel_type;

   typedef enum logic {
      DIV_EDGE,
      DIV_FINAL
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_CHECK,
      ST_LGS,
      ST_LGS_W,
      ST_LGN,
      ST_LGN_W,
      ST_RD,
      ST_RD_W,
      ST_LGW_W,
      ST_MUL,
      ST_DIV,
      ST_DIV_W,
      ST_NEXT,
      ST_FIN,
      ST_FIN_W,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic        load;
      logic        log_start;
      log_sel_type log_sel;
      logic        ls_save;
      logic        ln_save;
      logic        idx_clr;
      logic        idx_inc;
      logic        rd_en;
      logic        mul_en;
      logic        div_start;
      div_sel_type div_sel;
      logic        acc_add;
      logic        out_load;
      logic        clear;
   } cmd_type;

   typedef struct packed {
      logic degen;
      logic log_done;
      logic div_done;
      logic w_zero;
      logic idx_last;
      logic out_free;
   } stat_type;

endpackage

// ===== sv/nee_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module nee_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/nee_log.sv =====
// Iterative fixed-point log2 unit: normalizes, then squares once per fraction bit.
// Depends on nee_pkg.
module nee_log (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [nee_pkg::TOT_W-1:0] x,
   output logic                      done,
   output logic [nee_pkg::LG_W-1:0]  result
);
   import nee_pkg::*;

   localparam int CW = $clog2(LOG_FRAC);

   logic                busy_ff, busy_in;
   logic                norm_ff, norm_in;
   logic                done_ff, done_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [TOT_W-1:0]    x_ff, x_in;
   logic [LG_INT_W-1:0] e_ff, e_in;
   logic [31:0]         m_ff, m_in;
   logic [LOG_FRAC-1:0] frac_ff, frac_in;
   logic [63:0]         sq;
   logic [32:0]         t;

   always_comb begin
      sq      = 64'(m_ff) * 64'(m_ff);
      t       = sq[63:31];
      busy_in = busy_ff;
      norm_in = norm_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      e_in    = e_ff;
      m_in    = m_ff;
      frac_in = frac_ff;
      if (start) begin
         busy_in = 1'b1;
         norm_in = 1'b1;
         cnt_in  = '0;
         x_in    = x;
         e_in    = LG_INT_W'(TOT_W - 1);
         frac_in = '0;
      end else if (busy_ff && norm_ff) begin
         if (x_ff[TOT_W-1]) begin
            m_in    = x_ff[TOT_W-1 -: 32];
            norm_in = 1'b0;
         end else if (x_ff[TOT_W-1 -: 8] == 8'd0) begin
            x_in = {x_ff[TOT_W-9:0], 8'd0};
            e_in = e_ff - LG_INT_W'(8);
         end else begin
            x_in = {x_ff[TOT_W-2:0], 1'b0};
            e_in = e_ff - LG_INT_W'(1);
         end
      end else if (busy_ff) begin
         if (t[32]) begin
            m_in    = t[32:1];
            frac_in = {frac_ff[LOG_FRAC-2:0], 1'b1};
         end else begin
            m_in    = t[31:0];
            frac_in = {frac_ff[LOG_FRAC-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(LOG_FRAC - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         norm_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         norm_ff <= norm_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff    <= x_in;
      e_ff    <= e_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
   end

   assign done   = done_ff;
   assign result = {e_ff, frac_ff};

endmodule

// ===== sv/nee_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
// Depends on nee_pkg.
module nee_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [nee_pkg::DIV_W-1:0] num,
   input  logic [nee_pkg::TOT_W-1:0] den,
   output logic                      done,
   output logic [nee_pkg::DIV_W-1:0] quot
);
   import nee_pkg::*;

   localparam int CW = $clog2(DIV_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DIV_W-1:0] num_ff, num_in;
   logic [TOT_W-1:0] den_ff, den_in;
   logic [TOT_W-1:0] rem_ff, rem_in;
   logic [TOT_W:0]   r;
   logic [TOT_W:0]   diff;
   logic             ge;

   always_comb begin
      r       = {rem_ff, num_ff[DIV_W-1]};
      ge      = r >= {1'b0, den_ff};
      diff    = r - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[TOT_W-1:0] : r[TOT_W-1:0];
         num_in = {num_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule

// ===== sv/nee_dp.sv =====
// Datapath: weight store, running sum and tally, log and divide units, accumulator
// and result register. Depends on nee_pkg, nee_ram, nee_log and nee_div.
module nee_dp #(
   parameter int MAX_DEGREE = 1024,
   parameter int FRAC_BITS  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  nee_pkg::cmd_type       cmd,
   output nee_pkg::stat_type      stat,
   input  logic [31:0]            req_vertex_ident,
   input  logic [31:0]            req_weight,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [31:0]            rsp_result_vertex,
   output logic [FRAC_BITS:0]     rsp_diversity,
   output logic                   rsp_degenerate
);
   import nee_pkg::*;

   localparam int AW = $clog2(MAX_DEGREE);
   localparam int TW = $clog2(MAX_DEGREE + 1);
   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   logic [TW-1:0]     tally_ff, tally_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [31:0]       vid_ff, vid_in;
   logic [LG_W-1:0]   ls_ff, ls_in;
   logic [LG_W-1:0]   ln_ff, ln_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              valid_ff, valid_in;
   logic [31:0]       ovid_ff, ovid_in;
   logic [FRAC_BITS:0] div_ff, div_in;
   logic              degen_ff, degen_in;

   logic              wr_en;
   logic [TOT_W:0]    sum;
   logic [31:0]       rdata;
   logic [TOT_W-1:0]  log_x;
   logic              log_done;
   logic [LG_W-1:0]   log_res;
   logic [LG_W-1:0]   d;
   logic [DIV_W-1:0]  div_num;
   logic [TOT_W-1:0]  div_den;
   logic              div_done;
   logic [DIV_W-1:0]  quot;
   logic              degen;

   nee_ram #(.WIDTH(32), .DEPTH(MAX_DEGREE)) u_store (
      .clock (clock),
      .we    (wr_en),
      .waddr (tally_ff[AW-1:0]),
      .wdata (req_weight),
      .re    (cmd.rd_en),
      .raddr (idx_ff),
      .rdata (rdata)
   );

   nee_log u_log (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.log_start),
      .x      (log_x),
      .done   (log_done),
      .result (log_res)
   );

   nee_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (quot)
   );

   always_comb begin
      wr_en = cmd.load && (tally_ff < TW'(MAX_DEGREE));
      sum   = {1'b0, total_ff} + (TOT_W + 1)'(req_weight);
      degen = (tally_ff < TW'(2)) || (total_ff == '0);
      d     = (ls_ff > log_res) ? (ls_ff - log_res) : '0;
      case (cmd.log_sel)
         LOG_TOTAL:  log_x = total_ff;
         LOG_TALLY:  log_x = TOT_W'(tally_ff);
         LOG_WEIGHT: log_x = TOT_W'(rdata);
         default:    log_x = total_ff;
      endcase
      if (cmd.div_sel == DIV_FINAL) begin
         div_num = DIV_W'({acc_ff, {FRAC_BITS{1'b0}}});
         div_den = TOT_W'(ln_ff);
      end else begin
         div_num = DIV_W'(prod_ff);
         div_den = total_ff;
      end
   end

   always_comb begin
      tally_in = tally_ff;
      total_in = total_ff;
      acc_in   = acc_ff;
      vid_in   = vid_ff;
      ls_in    = cmd.ls_save ? log_res : ls_ff;
      ln_in    = cmd.ln_save ? log_res : ln_ff;
      idx_in   = idx_ff;
      prod_in  = cmd.mul_en ? PROD_W'(rdata) * PROD_W'(d) : prod_ff;
      valid_in = valid_ff && !rsp_ready;
      ovid_in  = ovid_ff;
      div_in   = div_ff;
      degen_in = degen_ff;
      if (cmd.load) begin
         vid_in = req_vertex_ident;
      end
      if (wr_en) begin
         tally_in = tally_ff + TW'(1);
         total_in = sum[TOT_W] ? {TOT_W{1'b1}} : sum[TOT_W-1:0];
      end
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + AW'(1);
      end
      if (cmd.acc_add) begin
         acc_in = acc_ff + quot[ACC_W-1:0];
      end
      if (cmd.out_load) begin
         valid_in = 1'b1;
         ovid_in  = vid_ff;
         degen_in = degen;
         if (degen) begin
            div_in = '0;
         end else if (quot > DIV_W'(ONE)) begin
            div_in = ONE;
         end else begin
            div_in = quot[FRAC_BITS:0];
         end
      end
      if (cmd.clear) begin
         tally_in = '0;
         total_in = '0;
         acc_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tally_ff <= '0;
         total_ff <= '0;
         acc_ff   <= '0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         tally_ff <= tally_in;
         total_ff <= total_in;
         acc_ff   <= acc_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      vid_ff   <= vid_in;
      ls_ff    <= ls_in;
      ln_ff    <= ln_in;
      prod_ff  <= prod_in;
      ovid_ff  <= ovid_in;
      div_ff   <= div_in;
      degen_ff <= degen_in;
   end

   always_comb begin
      stat.degen    = degen;
      stat.log_done = log_done;
      stat.div_done = div_done;
      stat.w_zero   = (rdata == 32'd0);
      stat.idx_last = (TW'(idx_ff) + TW'(1)) == tally_ff;
      stat.out_free = !valid_ff || rsp_ready;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_result_vertex = ovid_ff;
   assign rsp_diversity     = div_ff;
   assign rsp_degenerate    = degen_ff;

endmodule

// ===== sv/nee_ctrl.sv =====
// Controller state machine that sequences loading, the per-edge pass and the result.
// Depends on nee_pkg.
module nee_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_last_edge,
   output logic              req_ready,
   input  nee_pkg::stat_type stat,
   output nee_pkg::cmd_type  cmd
);
   import nee_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid && req_last_edge) state_in = ST_CHECK;
         end
         ST_CHECK: state_in = stat.degen ? ST_OUT : ST_LGS;
         ST_LGS:   state_in = ST_LGS_W;
         ST_LGS_W: begin
            if (stat.log_done) state_in = ST_LGN;
         end
         ST_LGN:   state_in = ST_LGN_W;
         ST_LGN_W: begin
            if (stat.log_done) state_in = ST_RD;
         end
         ST_RD:    state_in = ST_RD_W;
         ST_RD_W:  state_in = stat.w_zero ? ST_NEXT : ST_LGW_W;
         ST_LGW_W: begin
            if (stat.log_done) state_in = ST_MUL;
         end
         ST_MUL:   state_in = ST_DIV;
         ST_DIV:   state_in = ST_DIV_W;
         ST_DIV_W: begin
            if (stat.div_done) state_in = ST_NEXT;
         end
         ST_NEXT:  state_in = stat.idx_last ? ST_FIN : ST_RD;
         ST_FIN:   state_in = ST_FIN_W;
         ST_FIN_W: begin
            if (stat.div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (stat.out_free) state_in = ST_LOAD;
         end
         default:  state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.log_sel = LOG_TOTAL;
      cmd.div_sel = DIV_EDGE;
      req_ready   = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_LGS: begin
            cmd.log_start = 1'b1;
            cmd.log_sel   = LOG_TOTAL;
         end
         ST_LGS_W: cmd.ls_save = stat.log_done;
         ST_LGN: begin
            cmd.log_start = 1'b1;
            cmd.log_sel   = LOG_TALLY;
         end
         ST_LGN_W: begin
            cmd.ln_save = stat.log_done;
            cmd.idx_clr = 1'b1;
         end
         ST_RD:    cmd.rd_en = 1'b1;
         ST_RD_W: begin
            cmd.log_start = !stat.w_zero;
            cmd.log_sel   = LOG_WEIGHT;
         end
         ST_MUL:   cmd.mul_en = 1'b1;
         ST_DIV:   cmd.div_start = 1'b1;
         ST_DIV_W: cmd.acc_add = stat.div_done;
         ST_NEXT:  cmd.idx_inc = !stat.idx_last;
         ST_FIN: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_FINAL;
         end
         ST_FIN_W: cmd.div_sel = DIV_FINAL;
         ST_OUT: begin
            cmd.out_load = stat.out_free;
            cmd.clear    = stat.out_free;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/normalized_edge_entropy.sv =====
// Normalized edge entropy block: the weights of one vertex arrive as requests,
// one per cycle while the block is loading, on the req_ channel; req_last_edge
// marks the final weight. Up to MAX_DEGREE weights are stored and added to a
// saturating running sum as they are taken; later ones are dropped. After the
// last weight the block runs a second pass over the stored weights: a zero
// weight is skipped after its read, and a nonzero weight goes through the
// iterative log2 unit and the bit-serial divider. Two logs run before the pass
// and one final division follows it. A vertex with fewer than two weights or a
// zero sum reports at once with rsp_degenerate set and a diversity of zero.
// The result is held in an output register on the rsp_ channel; while it waits
// the block already takes the next vertex's weights, and it stalls before
// writing a new result only if the previous one has not been taken.
// Synchronous reset clears the running state and drops any pending result;
// the weight store needs no clearing.
// Depends on nee_pkg, nee_ctrl, nee_dp and the assertion macros header.
`include "normalized_edge_entropy_macros.svh"

module normalized_edge_entropy #(
   parameter int MAX_DEGREE = 1024,
   parameter int FRAC_BITS  = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_vertex_ident,
   input  logic [31:0]        req_weight,
   input  logic               req_last_edge,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_result_vertex,
   output logic [FRAC_BITS:0] rsp_diversity,
   output logic               rsp_degenerate
);
   import nee_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   logic               last_take;
   logic               degen_out;
   logic [FRAC_BITS:0] div_one;

   nee_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_edge (req_last_edge),
      .req_ready     (req_ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   nee_dp #(.MAX_DEGREE(MAX_DEGREE), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_vertex_ident  (req_vertex_ident),
      .req_weight        (req_weight),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_result_vertex (rsp_result_vertex),
      .rsp_diversity     (rsp_diversity),
      .rsp_degenerate    (rsp_degenerate)
   );

   assign last_take = req_valid && req_ready && req_last_edge;
   assign degen_out = rsp_valid && rsp_degenerate;
   assign div_one   = {1'b1, {FRAC_BITS{1'b0}}};

   `NEE_ASSERT_NEXT(a_last_stops_input, last_take, !req_ready, "input open after last edge")
   `NEE_ASSERT_NOW(a_degen_zero, degen_out, rsp_diversity == '0, "nonzero degenerate result")
   `NEE_ASSERT_NOW(a_div_range, rsp_valid, rsp_diversity <= div_one, "diversity above one")

endmodule

// ===== tb/sv/nee_checker.sv =====
`timescale 1ns / 1ps
// Checker for the normalized edge entropy block: watches both channels, predicts
// each vertex's diversity with a fixed-point log2 and division, and compares.
// Depends only on the port widths of normalized_edge_entropy (Q1.16 diversity).
module nee_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_vertex_ident,
   input  logic [31:0] req_weight,
   input  logic        req_last_edge,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_result_vertex,
   input  logic [16:0] rsp_diversity,
   input  logic        rsp_degenerate,
   output int          error_count,
   output int          pending_count
);

   localparam int DEGREE_LIMIT = 1024;
   localparam logic [41:0] TOTAL_CEIL = {42{1'b1}};

   typedef struct packed {
      logic [31:0] vertex;
      logic [16:0] diversity;
      logic        degenerate;
   } diversity_result_type;

   logic [31:0] edge_weights [DEGREE_LIMIT];
   logic [41:0] running_total;
   int unsigned stored_edges;
   diversity_result_type expected_results [$];

   function automatic logic [29:0] log2_q24(input logic [41:0] x);
      int e;
      logic [63:0] m;
      logic [23:0] frac;
      e = 0;
      frac = '0;
      if (x == '0) return '0;
      for (int i = 0; i < 42; i++) if (x[i]) e = i;
      m = 64'(x);
      if (e >= 31) m = m >> (e - 31);
      else m = m << (31 - e);
      for (int i = 0; i < 24; i++) begin
         m = (m * m) >> 31;
         frac = {frac[22:0], 1'b0};
         if (m >= 64'h1_0000_0000) begin
            m = m >> 1;
            frac[0] = 1'b1;
         end
      end
      return {6'(e), frac};
   endfunction

   function automatic diversity_result_type vertex_diversity(input logic [31:0] vertex);
      diversity_result_type r;
      logic [29:0] lg_sum, lg_count, lg_w, diff;
      logic [39:0] acc;
      logic [63:0] q;
      r.vertex = vertex;
      r.diversity = '0;
      r.degenerate = 1'b0;
      acc = '0;
      if (stored_edges < 2 || running_total == '0) begin
         r.degenerate = 1'b1;
         return r;
      end
      lg_sum = log2_q24(running_total);
      lg_count = log2_q24(42'(stored_edges));
      for (int i = 0; i < stored_edges; i++) begin
         if (edge_weights[i] != '0) begin
            lg_w = log2_q24(42'(edge_weights[i]));
            diff = (lg_sum > lg_w) ? lg_sum - lg_w : '0;
            acc = 40'(64'(acc) + (64'(edge_weights[i]) * 64'(diff)) / 64'(running_total));
         end
      end
      q = (64'(acc) << 16) / 64'(lg_count);
      if (q > 64'd65536) q = 64'd65536;
      r.diversity = q[16:0];
      return r;
   endfunction

   always @(posedge clock) begin
      diversity_result_type want;
      logic [42:0] sum_next;
      if (reset) begin
         running_total = '0;
         stored_edges = 0;
         error_count <= 0;
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               error_count <= error_count + 1;
               if (error_count < 10)
                  $display("ERROR: unexpected result vertex=%h diversity=%0d degenerate=%0b",
                           rsp_result_vertex, rsp_diversity, rsp_degenerate);
            end else begin
               want = expected_results.pop_front();
               if (want.vertex !== rsp_result_vertex || want.diversity !== rsp_diversity ||
                   want.degenerate !== rsp_degenerate) begin
                  error_count <= error_count + 1;
                  if (error_count < 10)
                     $display("ERROR: vertex exp %h got %h, diversity exp %0d got %0d, %s%0b got %0b",
                              want.vertex, rsp_result_vertex, want.diversity, rsp_diversity,
                              "degenerate exp ", want.degenerate, rsp_degenerate);
               end
            end
         end
         if (req_valid && req_ready) begin
            if (stored_edges < DEGREE_LIMIT) begin
               edge_weights[stored_edges] = req_weight;
               stored_edges = stored_edges + 1;
               sum_next = 43'(running_total) + 43'(req_weight);
               running_total = (sum_next > 43'(TOTAL_CEIL)) ? TOTAL_CEIL : sum_next[41:0];
            end
            if (req_last_edge) begin
               expected_results.insert(expected_results.size(),
                                       vertex_diversity(req_vertex_ident));
               running_total = '0;
               stored_edges = 0;
            end
         end
      end
      pending_count <= expected_results.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the normalized edge entropy testbench: clock, reset, request stimulus,
// result-side stalls, watchdog and verdict. Depends on normalized_edge_entropy
// and nee_checker.
module tb_top;

   localparam int ITEM_TARGET = 1900;
   localparam int IDLE_LIMIT  = 400000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_vertex_ident;
   logic [31:0] req_weight;
   logic        req_last_edge;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_result_vertex;
   logic [16:0] rsp_diversity;
   logic        rsp_degenerate;
   int          error_count;
   int          pending_count;
   int          idle_cycles;
   int          items_sent;
   logic        burst_mode;

   normalized_edge_entropy u_top (.*);

   nee_checker u_checker (.*);

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (burst_mode || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [31:0] random_weight();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 15) return 32'hFFFF_FFFF;
      if (r < 50) return $urandom_range(1, 16);
      if (r < 70) return $urandom_range(1, 65535);
      return $urandom;
   endfunction

   task automatic send_weight(input logic [31:0] vertex, input logic [31:0] w,
                              input logic last);
      logic taken;
      int gap;
      req_valid <= 1'b1;
      req_vertex_ident <= vertex;
      req_weight <= w;
      req_last_edge <= last;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      items_sent++;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_vertex(input logic [31:0] vertex, input int degree);
      for (int i = 0; i < degree; i++)
         send_weight(vertex, random_weight(), i == degree - 1);
   endtask

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int hold;
      rsp_ready = 1'b0;
      @(negedge reset);
      repeat (1500) begin
         @(posedge clock);
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end
      @(posedge clock);
      rsp_ready <= 1'b0;
      repeat (6000) @(posedge clock);
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 9) < 7) begin
            rsp_ready <= 1'b1;
         end else begin
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 400) : $urandom_range(1, 5);
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
      end
   end

   initial begin
      int degree;
      int vertex_no;
      logic [31:0] vid;
      reset = 1'b1;
      req_valid = 1'b0;
      req_vertex_ident = '0;
      req_weight = '0;
      req_last_edge = 1'b0;
      items_sent = 0;
      burst_mode = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Single edge, and single zero edge.
      send_weight(32'h0000_0000, 32'd7, 1'b1);
      send_weight(32'hFFFF_FFFF, 32'd0, 1'b1);
      // All weights zero.
      send_weight(32'h0000_0011, 32'd0, 1'b0);
      send_weight(32'h0000_0011, 32'd0, 1'b1);
      // Equal weights give full diversity.
      for (int i = 0; i < 4; i++) send_weight(32'h0000_0022, 32'd5, i == 3);
      // Extreme weights and a zero edge among them.
      send_weight(32'hA5A5_5A5A, 32'hFFFF_FFFF, 1'b0);
      send_weight(32'hA5A5_5A5A, 32'd1, 1'b0);
      send_weight(32'hA5A5_5A5A, 32'd0, 1'b0);
      send_weight(32'hA5A5_5A5A, 32'hFFFF_FFFF, 1'b1);
      // Mixed vertex identifiers within one vertex.
      send_weight(32'h1234_5678, 32'd100, 1'b0);
      send_weight(32'h8765_4321, 32'd3, 1'b0);
      send_weight(32'h5555_AAAA, 32'h8000_0000, 1'b1);
      // Two distinct weights.
      send_weight(32'h0000_0033, 32'd1, 1'b0);
      send_weight(32'h0000_0033, 32'd3, 1'b1);

      vertex_no = 0;
      while (items_sent < ITEM_TARGET) begin
         vertex_no++;
         if (vertex_no % 15 == 0) burst_mode = ~burst_mode;
         vid = ($urandom_range(0, 3) == 0) ? $urandom : 32'(vertex_no);
         if (vertex_no == 40) begin
            // Over the degree limit with maximal weights.
            burst_mode = 1'b1;
            for (int i = 0; i < 1030; i++) send_weight(vid, 32'hFFFF_FFFF, i == 1029);
            burst_mode = 1'b0;
         end else begin
            degree = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 30);
            if ($urandom_range(0, 19) == 0) begin
               // Mixed identifiers on a random vertex.
               for (int i = 0; i < degree; i++)
                  send_weight($urandom, random_weight(), i == degree - 1);
            end else begin
               send_vertex(vid, degree);
            end
         end
      end
      burst_mode = 1'b0;
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
